/* design/spi_eeprom_transaction_sequencer_defines.svh */
// Assertion macros shared by the sequencer blocks
`ifndef SPI_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH
`define SPI_EEPROM_TRANSACTION_SEQUENCER_DEFINES_SVH

// Check an implication at every clock edge outside reset
`define SES_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition never holds outside reset
`define SES_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error(msg);

`endif

/* design/ses_pkg.sv */
// Shared types, codes and constants of the SPI EEPROM transaction sequencer
`default_nettype none

package ses_pkg;

  // Address counter
  localparam int ADDR_W = 24;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

  // Status polls made before a write is taken as complete
  localparam int POLL_W = 6;
  localparam logic [POLL_W-1:0] POLL_LIMIT = POLL_W'(50);

  // Request modes
  localparam logic [2:0] MODE_START_WRITE = 3'd0;
  localparam logic [2:0] MODE_WRITE_BYTE  = 3'd1;
  localparam logic [2:0] MODE_START_READ  = 3'd2;
  localparam logic [2:0] MODE_READ_BYTE   = 3'd3;
  localparam logic [2:0] MODE_END_READ    = 3'd4;
  localparam logic [2:0] MODE_REPLY       = 3'd5;
  localparam logic [2:0] MODE_STATUS_READ = 3'd6;

  // Result actions
  localparam logic [3:0] ACT_CS_LOW      = 4'd0;
  localparam logic [3:0] ACT_CS_HIGH     = 4'd1;
  localparam logic [3:0] ACT_SEND        = 4'd2;
  localparam logic [3:0] ACT_EXCHANGE    = 4'd3;
  localparam logic [3:0] ACT_SHORT_DELAY = 4'd4;
  localparam logic [3:0] ACT_POLL_DELAY  = 4'd5;
  localparam logic [3:0] ACT_READ_DATA   = 4'd6;
  localparam logic [3:0] ACT_STATUS_DATA = 4'd7;
  localparam logic [3:0] ACT_DONE        = 4'd8;

  // Device command bytes
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_WRITE = 8'h02;
  localparam logic [7:0] CMD_RDID  = 8'h83;
  localparam logic [7:0] CMD_WRID  = 8'h82;
  localparam logic [7:0] BYTE_DUMMY = 8'hFF;
  localparam int         STATUS_BUSY_BIT = 0;

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ADDR_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAGE_LOG2  = 1'b1;
  localparam logic [1:0] CFG_ADDR_BYTES_RST = 2'd2;
  localparam logic [3:0] CFG_PAGE_LOG2_RST  = 4'd6;

  typedef struct packed {
    logic [1:0] addr_bytes;
    logic [3:0] page_log2;
  } cfg_t;

  // Job kinds handed from the front to the back
  typedef logic [3:0] kind_t;
  localparam kind_t KIND_OPEN_WRITE  = 4'd0;
  localparam kind_t KIND_START_READ  = 4'd1;
  localparam kind_t KIND_SEND_DATA   = 4'd2;
  localparam kind_t KIND_POLL        = 4'd3;
  localparam kind_t KIND_STATUS      = 4'd4;
  localparam kind_t KIND_EXCH        = 4'd5;
  localparam kind_t KIND_CS_HIGH     = 4'd6;
  localparam kind_t KIND_READ_DATA   = 4'd7;
  localparam kind_t KIND_STATUS_DATA = 4'd8;
  localparam kind_t KIND_DONE        = 4'd9;

  typedef struct packed {
    logic              pre_cs_high; // raise chip select before the body
    kind_t             kind;
    logic              close;       // data byte closes the page and polls
    logic [7:0]        byte_val;    // command or data byte
    logic [ADDR_W-1:0] location;    // counter after the request
  } job_t;

  // One result beat before the end flag is added
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] value;
  } op_t;

  localparam int LEN_W = 4;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

endpackage

`default_nettype wire

/* design/ses_channels.sv */
// Handshake channels of the sequencer: requests, results and register writes
`default_nettype none

interface ses_in_if import ses_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [ADDR_W-1:0] address;
  logic [7:0]        data;
  logic              id_page;
  logic              last;

  modport source (output valid, mode, address, data, id_page, last, input ready);
  modport sink   (input valid, mode, address, data, id_page, last, output ready);
endinterface

interface ses_out_if import ses_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [3:0]        action;
  logic [7:0]        value;
  logic [ADDR_W-1:0] location;
  logic              end_of_run;

  modport source (output valid, action, value, location, end_of_run, input ready);
  modport sink   (input valid, action, value, location, end_of_run, output ready);
endinterface

interface ses_cfg_if import ses_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/spi_eeprom_transaction_sequencer.sv */
// Top level of the SPI EEPROM transaction sequencer
//
//  channel  | role   | beat carries
//  ---------+--------+------------------------------------------------
//  in_req   | sink   | mode, address, data, id_page, last
//  out_res  | source | action, value, location, end_of_run
//  cfg_wr   | sink   | index (0 address bytes, 1 page size log2), data
//
// A request causes 0 to 10 result beats; the action sequencer emits one beat
// per clock while the result side is not stalled, and it starts the next job
// on the beat that follows the last beat of the current job.
// The front end takes one request per clock while the two-entry job queue
// has room; requests that give no result are taken without entering the queue.
// Synchronous active-low reset clears phase, counters, queue and output valid,
// and sets address bytes to 2 and page size log2 to 6. The result stage is a
// registered output, and the front keeps accepting while a result waits.
`default_nettype none

module spi_eeprom_transaction_sequencer import ses_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ses_in_if.sink     in_req,
  ses_out_if.source  out_res,
  ses_cfg_if.sink    cfg_wr
);

  logic   push;
  job_t   push_job;
  logic   q_full;
  qhead_t q_head;
  logic   pop;
  cfg_t   cfg;

  ses_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cfg_wr   (cfg_wr),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .cfg      (cfg)
  );

  ses_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .head     (q_head),
    .pop      (pop)
  );

  ses_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (q_head),
    .pop     (pop),
    .cfg     (cfg),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

/* design/ses_front.sv */
// Request front end: register writes, phase tracking and job classification
`default_nettype none
`include "spi_eeprom_transaction_sequencer_defines.svh"

module ses_front import ses_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ses_in_if.sink      in_req,
  ses_cfg_if.sink     cfg_wr,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job,
  output cfg_t        cfg
);

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_WRITING     = 3'd1;
  localparam logic [2:0] PH_POLL_WAIT   = 3'd2;
  localparam logic [2:0] PH_READING     = 3'd3;
  localparam logic [2:0] PH_READ_WAIT   = 3'd4;
  localparam logic [2:0] PH_STATUS_WAIT = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [POLL_W-1:0] poll_count_r, poll_count_nxt;
  logic              idp_r, idp_nxt;
  logic              resume_r, resume_nxt;
  cfg_t              cfg_r, cfg_nxt;

  logic              accept;
  logic              produce;
  job_t              job;
  logic              no_addr;
  logic [ADDR_W-1:0] cnt_inc;
  logic [ADDR_W-1:0] page_mask;
  logic              boundary;

  assign in_req.ready = !q_full;
  assign cfg_wr.ready = 1'b1;
  assign accept       = in_req.valid && in_req.ready;
  assign push         = accept && produce;
  assign push_job     = job;
  assign cfg          = cfg_r;

  // Take register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_IDX_ADDR_BYTES: cfg_nxt.addr_bytes = cfg_wr.data[1:0];
        CFG_IDX_PAGE_LOG2:  cfg_nxt.page_log2  = cfg_wr.data[3:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // Page boundary after the counter steps
  assign no_addr   = (cfg_r.addr_bytes == 2'd0);
  assign cnt_inc   = (cnt_r + ADDR_W'(1)) & ADDR_MASK;
  assign page_mask = ~(ADDR_MASK << cfg_r.page_log2);
  assign boundary  = ((cnt_inc & page_mask) == '0);

  // Classify the request against the current phase
  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    poll_count_nxt = poll_count_r;
    idp_nxt        = idp_r;
    resume_nxt     = resume_r;
    produce        = 1'b0;
    job            = '0;
    case (in_req.mode)
      MODE_START_WRITE: begin
        if (phase_r == PH_IDLE) begin
          cnt_nxt      = in_req.address & ADDR_MASK;
          idp_nxt      = in_req.id_page;
          produce      = 1'b1;
          job.kind     = KIND_OPEN_WRITE;
          job.byte_val = in_req.id_page ? CMD_WRID : CMD_WRITE;
          phase_nxt    = no_addr ? PH_IDLE : PH_WRITING;
        end
      end
      MODE_WRITE_BYTE: begin
        if (phase_r == PH_WRITING) begin
          cnt_nxt      = cnt_inc;
          produce      = 1'b1;
          job.kind     = KIND_SEND_DATA;
          job.byte_val = in_req.data;
          if (in_req.last || boundary) begin
            job.close      = 1'b1;
            resume_nxt     = !in_req.last;
            poll_count_nxt = POLL_W'(1);
            phase_nxt      = PH_POLL_WAIT;
          end
        end
      end
      MODE_START_READ: begin
        if (phase_r == PH_IDLE) begin
          cnt_nxt      = in_req.address & ADDR_MASK;
          idp_nxt      = in_req.id_page;
          produce      = 1'b1;
          job.kind     = KIND_START_READ;
          job.byte_val = in_req.id_page ? CMD_RDID : CMD_READ;
          phase_nxt    = no_addr ? PH_IDLE : PH_READING;
        end
      end
      MODE_READ_BYTE: begin
        if (phase_r == PH_READING) begin
          produce   = 1'b1;
          job.kind  = KIND_EXCH;
          phase_nxt = PH_READ_WAIT;
        end
      end
      MODE_END_READ: begin
        if (phase_r == PH_READING) begin
          produce   = 1'b1;
          job.kind  = KIND_CS_HIGH;
          phase_nxt = PH_IDLE;
        end
      end
      MODE_REPLY: begin
        if (phase_r == PH_READ_WAIT) begin
          cnt_nxt      = cnt_inc;
          produce      = 1'b1;
          job.kind     = KIND_READ_DATA;
          job.byte_val = in_req.data;
          phase_nxt    = PH_READING;
        end else if (phase_r == PH_STATUS_WAIT) begin
          produce         = 1'b1;
          job.pre_cs_high = 1'b1;
          job.kind        = KIND_STATUS_DATA;
          job.byte_val    = in_req.data;
          phase_nxt       = PH_IDLE;
        end else if (phase_r == PH_POLL_WAIT) begin
          produce         = 1'b1;
          job.pre_cs_high = 1'b1;
          if (in_req.data[STATUS_BUSY_BIT] && (poll_count_r < POLL_LIMIT)) begin
            poll_count_nxt = poll_count_r + POLL_W'(1);
            job.kind       = KIND_POLL;
          end else if (resume_r) begin
            resume_nxt   = 1'b0;
            job.kind     = KIND_OPEN_WRITE;
            job.byte_val = idp_r ? CMD_WRID : CMD_WRITE;
            phase_nxt    = no_addr ? PH_IDLE : PH_WRITING;
          end else begin
            job.kind  = KIND_DONE;
            phase_nxt = PH_IDLE;
          end
        end
      end
      MODE_STATUS_READ: begin
        if (phase_r == PH_IDLE) begin
          produce   = 1'b1;
          job.kind  = KIND_STATUS;
          phase_nxt = PH_STATUS_WAIT;
        end
      end
      default: produce = 1'b0;
    endcase
    job.location = cnt_nxt;
  end

  // Take register writes; hold request state, advance it on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      cnt_r          <= '0;
      poll_count_r   <= '0;
      idp_r          <= 1'b0;
      resume_r       <= 1'b0;
      cfg_r.addr_bytes <= CFG_ADDR_BYTES_RST;
      cfg_r.page_log2  <= CFG_PAGE_LOG2_RST;
    end else begin
      cfg_r <= cfg_nxt;
      if (accept) begin
        phase_r      <= phase_nxt;
        cnt_r        <= cnt_nxt;
        poll_count_r <= poll_count_nxt;
        idp_r        <= idp_nxt;
        resume_r     <= resume_nxt;
      end
    end
  end

  `SES_ASSERT_IMPL(a_poll_count_range, clk, rst_n, phase_r == PH_POLL_WAIT, poll_count_r != '0 && poll_count_r <= POLL_LIMIT, "poll count out of range while polling")
  `SES_ASSERT_IMPL(a_resume_only_polling, clk, rst_n, resume_r, phase_r == PH_POLL_WAIT, "resume flag set outside a poll")

endmodule

`default_nettype wire

/* design/ses_queue.sv */
// Short job queue between the front end and the action sequencer
`default_nettype none
`include "spi_eeprom_transaction_sequencer_defines.svh"

module ses_queue import ses_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  job_t   push_job,
  output logic   full,
  output qhead_t head,
  input  logic   pop
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.job   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the job beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `SES_ASSERT_NEVER(a_queue_overflow, clk, rst_n, count_r > QCNT_W'(QUEUE_DEPTH), "job queue count above depth")

endmodule

`default_nettype wire

/* design/ses_back.sv */
// Action sequencer: expands jobs into beats, one per clock unless stalled
`default_nettype none
`include "spi_eeprom_transaction_sequencer_defines.svh"

module ses_back import ses_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  qhead_t head,
  output logic   pop,
  input  cfg_t   cfg,
  ses_out_if.source out_res
);

  // Beats in a job
  function automatic logic [LEN_W-1:0] job_len(job_t j, logic [1:0] ab);
    logic [LEN_W-1:0] tail;
    logic [LEN_W-1:0] body;
    tail = (ab == 2'd0) ? LEN_W'(1) : LEN_W'(ab);
    case (j.kind)
      KIND_OPEN_WRITE: body = LEN_W'(6) + tail;
      KIND_START_READ: body = LEN_W'(2) + tail;
      KIND_SEND_DATA:  body = j.close ? LEN_W'(6) : LEN_W'(1);
      KIND_POLL:       body = LEN_W'(4);
      KIND_STATUS:     body = LEN_W'(3);
      default:         body = LEN_W'(1);
    endcase
    return body + LEN_W'(j.pre_cs_high);
  endfunction

  // Address byte k (from 1) after a command, or raise chip select with none
  function automatic op_t addr_op(job_t j, logic [1:0] ab, logic [LEN_W-1:0] k);
    op_t        o;
    logic [1:0] sel;
    sel = ab - k[1:0];
    o.value = 8'h00;
    if (ab == 2'd0) begin
      o.action = ACT_CS_HIGH;
    end else begin
      o.action = ACT_SEND;
      case (sel)
        2'd0:    o.value = j.location[7:0];
        2'd1:    o.value = j.location[15:8];
        2'd2:    o.value = j.location[23:16];
        default: o.value = 8'h00;
      endcase
    end
    return o;
  endfunction

  // Poll sequence: delay, select, read status command, dummy exchange
  function automatic op_t poll_op(logic [LEN_W-1:0] p);
    op_t o;
    o.value = 8'h00;
    case (p)
      4'd0:    o.action = ACT_POLL_DELAY;
      4'd1:    o.action = ACT_CS_LOW;
      4'd2:    begin o.action = ACT_SEND;     o.value = CMD_RDSR;   end
      default: begin o.action = ACT_EXCHANGE; o.value = BYTE_DUMMY; end
    endcase
    return o;
  endfunction

  // Beat at position idx of a job
  function automatic op_t job_op(job_t j, logic [1:0] ab, logic [LEN_W-1:0] idx);
    op_t              o;
    logic [LEN_W-1:0] b;
    b = idx - LEN_W'(j.pre_cs_high);
    o.action = ACT_CS_LOW;
    o.value  = 8'h00;
    if (j.pre_cs_high && (idx == '0)) begin
      o.action = ACT_CS_HIGH;
    end else begin
      case (j.kind)
        KIND_OPEN_WRITE: begin
          case (b)
            4'd0:    o.action = ACT_CS_LOW;
            4'd1:    begin o.action = ACT_SEND; o.value = CMD_WREN; end
            4'd2:    o.action = ACT_CS_HIGH;
            4'd3:    o.action = ACT_SHORT_DELAY;
            4'd4:    o.action = ACT_CS_LOW;
            4'd5:    begin o.action = ACT_SEND; o.value = j.byte_val; end
            default: o = addr_op(j, ab, b - LEN_W'(5));
          endcase
        end
        KIND_START_READ: begin
          case (b)
            4'd0:    o.action = ACT_CS_LOW;
            4'd1:    begin o.action = ACT_SEND; o.value = j.byte_val; end
            default: o = addr_op(j, ab, b - LEN_W'(1));
          endcase
        end
        KIND_SEND_DATA: begin
          case (b)
            4'd0:    begin o.action = ACT_SEND; o.value = j.byte_val; end
            4'd1:    o.action = ACT_CS_HIGH;
            default: o = poll_op(b - LEN_W'(2));
          endcase
        end
        KIND_POLL: o = poll_op(b);
        KIND_STATUS: begin
          case (b)
            4'd0:    o.action = ACT_CS_LOW;
            4'd1:    begin o.action = ACT_SEND;     o.value = CMD_RDSR;   end
            default: begin o.action = ACT_EXCHANGE; o.value = BYTE_DUMMY; end
          endcase
        end
        KIND_EXCH:        begin o.action = ACT_EXCHANGE;    o.value = BYTE_DUMMY; end
        KIND_CS_HIGH:     o.action = ACT_CS_HIGH;
        KIND_READ_DATA:   begin o.action = ACT_READ_DATA;   o.value = j.byte_val; end
        KIND_STATUS_DATA: begin o.action = ACT_STATUS_DATA; o.value = j.byte_val; end
        KIND_DONE:        o.action = ACT_DONE;
        default:          o.action = ACT_DONE;
      endcase
    end
    return o;
  endfunction

  logic              busy_r, busy_nxt;
  job_t              job_r, job_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [LEN_W-1:0]  cur_len;
  op_t               cur_op;
  logic              fire;
  logic              fire_last;

  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_action_r;
  logic [7:0]        out_value_r;
  logic [ADDR_W-1:0] out_location_r;
  logic              out_eor_r;

  assign cur_len   = job_len(job_r, cfg.addr_bytes);
  assign cur_op    = job_op(job_r, cfg.addr_bytes, idx_r);
  assign fire      = busy_r && (!out_valid_r || out_res.ready);
  assign fire_last = fire && (idx_r == cur_len - LEN_W'(1));
  assign pop       = head.valid && (!busy_r || fire_last);

  // Step through the job, load the next one behind the last beat
  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    if (fire) begin
      idx_nxt = fire_last ? '0 : idx_r + LEN_W'(1);
    end
    if (fire_last) begin
      busy_nxt = 1'b0;
    end
    if (pop) begin
      busy_nxt = 1'b1;
      job_nxt  = head.job;
      idx_nxt  = '0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the job and the result payload
  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (fire) begin
      out_action_r   <= cur_op.action;
      out_value_r    <= cur_op.value;
      out_location_r <= job_r.location;
      out_eor_r      <= fire_last;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.action     = out_action_r;
  assign out_res.value      = out_value_r;
  assign out_res.location   = out_location_r;
  assign out_res.end_of_run = out_eor_r;

  `SES_ASSERT_IMPL(a_idx_in_job, clk, rst_n, busy_r, idx_r < cur_len, "beat index past end of job")

endmodule

`default_nettype wire

/* verif/ses_tb_pkg.sv */
// Phase codes, request and result beat types shared by the sequencer testbench
package ses_tb_pkg;
  import ses_pkg::*;

  // Mode code that no request uses
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // Transaction phase tracked by the predictor
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WRITING,
    PH_POLL_WAIT,
    PH_READING,
    PH_READ_WAIT,
    PH_STATUS_WAIT
  } seq_phase_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [7:0]        data;
    logic              id_page;
    logic              last;
  } request_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [7:0]        value;
    logic [ADDR_W-1:0] location;
    logic              end_of_run;
  } result_beat_t;

endpackage

/* verif/ses_action_checker.sv */
// Watches the sequencer channels, predicts each result beat and compares it
module ses_action_checker import ses_pkg::*; import ses_tb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ses_in_if          in_req,
  ses_out_if         out_res,
  ses_cfg_if         cfg_wr,
  output seq_phase_e seq_phase,
  output int         pending_beats,
  output int         beats_checked,
  output int         errors
);

  // Register copies
  logic [1:0]        addr_bytes;
  logic [3:0]        page_log2;

  // Transaction state
  seq_phase_e        phase;
  logic [ADDR_W-1:0] addr_count;
  logic [POLL_W-1:0] poll_tally;
  logic              id_select;
  logic              reopen_after_poll;

  result_beat_t      beats_due[$];
  result_beat_t      batch[$];

  // Queue one action at the current address count
  task automatic note(logic [3:0] action, logic [7:0] value);
    result_beat_t b;
    b.action     = action;
    b.value      = value;
    b.location   = addr_count;
    b.end_of_run = 1'b0;
    batch.push_back(b);
  endtask

  // Command byte, then address bytes from the high end of the counter down
  task automatic send_command(input logic [7:0] cmd, output logic opened);
    note(ACT_SEND, cmd);
    opened = (addr_bytes != 2'd0);
    if (!opened) begin
      note(ACT_CS_HIGH, 8'h00);
    end else begin
      for (int i = addr_bytes; i > 0; i--)
        note(ACT_SEND, addr_count[8*(i-1) +: 8]);
    end
  endtask

  task automatic open_write();
    logic opened;
    note(ACT_CS_LOW, 8'h00);
    note(ACT_SEND, CMD_WREN);
    note(ACT_CS_HIGH, 8'h00);
    note(ACT_SHORT_DELAY, 8'h00);
    note(ACT_CS_LOW, 8'h00);
    send_command(id_select ? CMD_WRID : CMD_WRITE, opened);
    phase = opened ? PH_WRITING : PH_IDLE;
  endtask

  task automatic start_poll();
    note(ACT_POLL_DELAY, 8'h00);
    note(ACT_CS_LOW, 8'h00);
    note(ACT_SEND, CMD_RDSR);
    note(ACT_EXCHANGE, BYTE_DUMMY);
    phase = PH_POLL_WAIT;
  endtask

  // Work out the beats that one accepted request causes
  task automatic plan_request(request_t r);
    logic              opened;
    logic [ADDR_W-1:0] page_mask;
    batch.delete();
    case (r.mode)
      MODE_START_WRITE: begin
        if (phase == PH_IDLE) begin
          addr_count = r.address;
          id_select  = r.id_page;
          open_write();
        end
      end
      MODE_WRITE_BYTE: begin
        if (phase == PH_WRITING) begin
          addr_count = addr_count + ADDR_W'(1);
          note(ACT_SEND, r.data);
          page_mask = (ADDR_W'(1) << page_log2) - ADDR_W'(1);
          if (r.last || (addr_count & page_mask) == '0) begin
            note(ACT_CS_HIGH, 8'h00);
            reopen_after_poll = !r.last;
            poll_tally = POLL_W'(1);
            start_poll();
          end
        end
      end
      MODE_START_READ: begin
        if (phase == PH_IDLE) begin
          addr_count = r.address;
          id_select  = r.id_page;
          note(ACT_CS_LOW, 8'h00);
          send_command(r.id_page ? CMD_RDID : CMD_READ, opened);
          phase = opened ? PH_READING : PH_IDLE;
        end
      end
      MODE_READ_BYTE: begin
        if (phase == PH_READING) begin
          note(ACT_EXCHANGE, BYTE_DUMMY);
          phase = PH_READ_WAIT;
        end
      end
      MODE_END_READ: begin
        if (phase == PH_READING) begin
          note(ACT_CS_HIGH, 8'h00);
          phase = PH_IDLE;
        end
      end
      MODE_REPLY: begin
        if (phase == PH_READ_WAIT) begin
          addr_count = addr_count + ADDR_W'(1);
          note(ACT_READ_DATA, r.data);
          phase = PH_READING;
        end else if (phase == PH_STATUS_WAIT) begin
          note(ACT_CS_HIGH, 8'h00);
          note(ACT_STATUS_DATA, r.data);
          phase = PH_IDLE;
        end else if (phase == PH_POLL_WAIT) begin
          note(ACT_CS_HIGH, 8'h00);
          // Poll again while busy and under the limit, else resume or finish
          if (r.data[STATUS_BUSY_BIT] && poll_tally < POLL_LIMIT) begin
            poll_tally = poll_tally + POLL_W'(1);
            start_poll();
          end else if (reopen_after_poll) begin
            reopen_after_poll = 1'b0;
            open_write();
          end else begin
            note(ACT_DONE, 8'h00);
            phase = PH_IDLE;
          end
        end
      end
      MODE_STATUS_READ: begin
        if (phase == PH_IDLE) begin
          note(ACT_CS_LOW, 8'h00);
          note(ACT_SEND, CMD_RDSR);
          note(ACT_EXCHANGE, BYTE_DUMMY);
          phase = PH_STATUS_WAIT;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) begin
      batch[batch.size()-1].end_of_run = 1'b1;
      foreach (batch[k]) beats_due.push_back(batch[k]);
    end
  endtask

  task automatic flag_mismatch(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Track registers and requests, then compare each result beat
  always @(posedge clk) begin
    request_t     r;
    result_beat_t want;
    if (!rst_n) begin
      addr_bytes        = CFG_ADDR_BYTES_RST;
      page_log2         = CFG_PAGE_LOG2_RST;
      phase             = PH_IDLE;
      addr_count        = '0;
      poll_tally        = '0;
      id_select         = 1'b0;
      reopen_after_poll = 1'b0;
      beats_due.delete();
      beats_checked     = 0;
      errors            = 0;
    end else begin
      if (cfg_wr.valid && cfg_wr.ready) begin
        if (cfg_wr.index == CFG_IDX_ADDR_BYTES) addr_bytes = cfg_wr.data[1:0];
        else page_log2 = cfg_wr.data[3:0];
      end
      if (in_req.valid && in_req.ready) begin
        r.mode    = in_req.mode;
        r.address = in_req.address;
        r.data    = in_req.data;
        r.id_page = in_req.id_page;
        r.last    = in_req.last;
        plan_request(r);
      end
      if (out_res.valid && out_res.ready) begin
        beats_checked++;
        if (beats_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %0h/%0h/%0h/%0b",
                   $time, out_res.action, out_res.value, out_res.location, out_res.end_of_run);
        end else begin
          want = beats_due.pop_front();
          if (out_res.action != want.action)
            flag_mismatch("action", ADDR_W'(want.action), ADDR_W'(out_res.action));
          if (out_res.value != want.value)
            flag_mismatch("value", ADDR_W'(want.value), ADDR_W'(out_res.value));
          if (out_res.location != want.location)
            flag_mismatch("location", want.location, out_res.location);
          if (out_res.end_of_run != want.end_of_run)
            flag_mismatch("end_of_run", ADDR_W'(want.end_of_run), ADDR_W'(out_res.end_of_run));
        end
      end
    end
    seq_phase     = phase;
    pending_beats = beats_due.size();
  end

endmodule

/* verif/testbench.sv */
// Stimulus and verdict for the SPI EEPROM transaction sequencer
module testbench;
  import ses_pkg::*;
  import ses_tb_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  ses_in_if   req_ch();
  ses_out_if  res_ch();
  ses_cfg_if  cfg_ch();

  seq_phase_e seq_phase;
  int         pending_beats;
  int         beats_checked;
  int         errors;

  // Run state of the stimulus
  logic       calm = 1'b0;
  logic       stay_busy = 1'b0;
  logic       force_busy = 1'b0;
  seq_phase_e last_phase = PH_IDLE;
  logic [3:0] page_now = CFG_PAGE_LOG2_RST;
  int         requests_taken = 0;
  int         requests_ignored = 0;

  // Register settings per phase: address bytes use low bits, high bits must not matter
  logic [3:0] addr_bytes_plan [5] = '{4'b1101, 4'b0011, 4'b1100, 4'b0110, 4'b1111};
  logic [3:0] page_log2_plan  [5] = '{4'b0000, 4'b1001, 4'b1111, 4'b0011, 4'b0010};

  always #1 clk = ~clk;

  spi_eeprom_transaction_sequencer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_res(res_ch),
    .cfg_wr (cfg_ch)
  );

  ses_action_checker action_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_req       (req_ch),
    .out_res      (res_ch),
    .cfg_wr       (cfg_ch),
    .seq_phase    (seq_phase),
    .pending_beats(pending_beats),
    .beats_checked(beats_checked),
    .errors       (errors)
  );

  // Stall the result side in random bursts, never in the calm part
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 16);
        res_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // Present one request from a falling edge and hold it until taken
  task automatic offer(input request_t r, output logic taken);
    case (r.mode)
      MODE_START_WRITE, MODE_START_READ, MODE_STATUS_READ: taken = (seq_phase == PH_IDLE);
      MODE_WRITE_BYTE: taken = (seq_phase == PH_WRITING);
      MODE_READ_BYTE, MODE_END_READ: taken = (seq_phase == PH_READING);
      MODE_REPLY: taken = (seq_phase == PH_POLL_WAIT || seq_phase == PH_READ_WAIT ||
                           seq_phase == PH_STATUS_WAIT);
      default: taken = 1'b0;
    endcase
    if (taken) requests_taken++;
    else requests_ignored++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid   = 1'b1;
    req_ch.mode    = r.mode;
    req_ch.address = r.address;
    req_ch.data    = r.data;
    req_ch.id_page = r.id_page;
    req_ch.last    = r.last;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic request(logic [2:0] mode, logic [ADDR_W-1:0] addr, logic [7:0] data,
                         logic idp, logic last_byte);
    request_t r;
    logic     taken;
    r = '{mode, addr, data, idp, last_byte};
    @(negedge clk);
    offer(r, taken);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = index;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Drop the request valid and wait until every expected beat has come
  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Choose a request that fits the predicted phase, with some noise
  task automatic pick_request(input logic wind_down, output request_t r);
    seq_phase_e        ph;
    logic [ADDR_W-1:0] page_mask;
    int                roll;
    int                shape;
    ph        = seq_phase;
    page_mask = (ADDR_W'(1) << page_now) - ADDR_W'(1);
    roll      = $urandom_range(0, 99);
    shape     = $urandom_range(0, 2);
    r.mode    = MODE_UNUSED;
    r.address = ADDR_W'($urandom());
    r.data    = 8'($urandom());
    r.id_page = 1'($urandom());
    r.last    = wind_down || ($urandom_range(0, 5) == 0);
    // Decide once per poll episode whether the device stays busy throughout
    if (ph == PH_POLL_WAIT && last_phase != PH_POLL_WAIT) begin
      stay_busy  = force_busy || ($urandom_range(0, 11) == 0);
      force_busy = 1'b0;
    end
    last_phase = ph;
    if (!wind_down && roll < 8) begin
      r.mode = 3'($urandom_range(0, 7));
    end else begin
      case (ph)
        PH_IDLE: begin
          if (roll < 50) r.mode = MODE_START_WRITE;
          else if (roll < 80) r.mode = MODE_START_READ;
          else r.mode = MODE_STATUS_READ;
          // Start close to a page end or to the top of the address space
          if (shape == 1)
            r.address = (r.address & ~page_mask) |
                        ((page_mask - ADDR_W'($urandom_range(0, 2))) & page_mask);
          else if (shape == 2)
            r.address = ADDR_MASK - ADDR_W'($urandom_range(0, 2));
        end
        PH_WRITING: r.mode = MODE_WRITE_BYTE;
        PH_READING: r.mode = (wind_down || roll >= 75) ? MODE_END_READ : MODE_READ_BYTE;
        default: begin
          r.mode = MODE_REPLY;
          if (ph == PH_POLL_WAIT) r.data[STATUS_BUSY_BIT] = stay_busy | 1'($urandom());
        end
      endcase
    end
  endtask

  // Random traffic until the quota is met and the sequencer is back to idle
  task automatic run_traffic(int quota);
    request_t r;
    logic     taken;
    int       counted;
    counted = 0;
    forever begin
      @(negedge clk);
      if (counted >= quota && seq_phase == PH_IDLE) break;
      pick_request(counted >= quota, r);
      offer(r, taken);
      if (taken) counted++;
    end
    req_ch.valid = 1'b0;
  endtask

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.mode    = MODE_START_WRITE;
    req_ch.address = '0;
    req_ch.data    = 8'h00;
    req_ch.id_page = 1'b0;
    req_ch.last    = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_IDX_ADDR_BYTES;
    cfg_ch.data    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Status read, then reads of the array at the top address and of the ID page
    request(MODE_STATUS_READ, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_REPLY, '0, 8'hA5, 1'b0, 1'b0);
    request(MODE_START_READ, ADDR_MASK, 8'h00, 1'b0, 1'b0);
    request(MODE_READ_BYTE, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_REPLY, '0, 8'hFF, 1'b0, 1'b0);
    request(MODE_END_READ, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_START_READ, '0, 8'h00, 1'b1, 1'b0);
    request(MODE_READ_BYTE, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_REPLY, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_END_READ, '0, 8'h00, 1'b0, 1'b0);
    // Write across a page boundary: busy once, then reopen and finish
    request(MODE_START_WRITE, ADDR_W'(24'h00003E), 8'h00, 1'b0, 1'b0);
    request(MODE_WRITE_BYTE, '0, 8'hFF, 1'b0, 1'b0);
    request(MODE_WRITE_BYTE, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_REPLY, '0, 8'h01, 1'b0, 1'b0);
    request(MODE_REPLY, '0, 8'hFE, 1'b0, 1'b0);
    request(MODE_WRITE_BYTE, '0, 8'h5A, 1'b0, 1'b1);
    request(MODE_REPLY, '0, 8'h00, 1'b0, 1'b0);
    // ID-page write whose last byte also lands on a boundary
    request(MODE_START_WRITE, ADDR_W'(24'h7FFFFF), 8'h00, 1'b1, 1'b0);
    request(MODE_WRITE_BYTE, '0, 8'hC3, 1'b0, 1'b1);
    request(MODE_REPLY, '0, 8'h00, 1'b0, 1'b0);
    // Requests in the wrong phase, and the unused mode
    request(MODE_UNUSED, ADDR_MASK, 8'hFF, 1'b1, 1'b1);
    request(MODE_WRITE_BYTE, '0, 8'h11, 1'b0, 1'b1);
    request(MODE_REPLY, '0, 8'h22, 1'b0, 1'b0);
    request(MODE_READ_BYTE, '0, 8'h00, 1'b0, 1'b0);
    request(MODE_END_READ, '0, 8'h00, 1'b0, 1'b0);
    drain();

    // Random traffic under each register setting, the last one without stalls
    for (int p = 0; p < 5; p++) begin
      write_register(CFG_IDX_ADDR_BYTES, addr_bytes_plan[p]);
      write_register(CFG_IDX_PAGE_LOG2, page_log2_plan[p]);
      page_now = page_log2_plan[p];
      calm = (p == 4);
      if (p == 0) force_busy = 1'b1;
      run_traffic(40);
      drain();
    end

    $display("Covered %0d requests that took effect and %0d ignored ones over six settings.",
             requests_taken, requests_ignored);
    $display("Compared %0d result beats, polling up to the limit at least once.",
             beats_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Bound the run in case the sequencer stops handing back beats
  initial begin
    #1000000;
    $display("Timed out with %0d result beats outstanding", pending_beats);
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* spi_eeprom_transaction_sequencer.f */
+incdir+design
design/ses_pkg.sv
design/ses_channels.sv
design/ses_front.sv
design/ses_queue.sv
design/ses_back.sv
design/spi_eeprom_transaction_sequencer.sv
verif/ses_tb_pkg.sv
verif/ses_action_checker.sv
verif/testbench.sv
